### hdl/pdc_pkg.sv
// ----------------------------------------------------------------------------
// PID controller package
// Shared widths, register indexes, modes and reset values.
// ----------------------------------------------------------------------------
package pdc_pkg;

   localparam int DEFAULT_SAMPLE_WIDTH   = 16;
   localparam int DEFAULT_GAIN_FRAC_BITS = 8;

   localparam int GAIN_W      = 16;
   localparam int LIMIT_W     = 15;
   localparam int DRIVE_W     = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = {LIMIT_W{1'b1}};

   typedef enum logic {
      MODE_POSITIONAL  = 1'b0,
      MODE_INCREMENTAL = 1'b1
   } mode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MODE           = 3'd0,
      CSR_KP_GAIN        = 3'd1,
      CSR_KI_GAIN        = 3'd2,
      CSR_KD_GAIN        = 3'd3,
      CSR_OUT_LIMIT      = 3'd4,
      CSR_INTEGRAL_LIMIT = 3'd5
   } csr_index_type;

endpackage

### hdl/pid_position_delta_controller.sv
// ----------------------------------------------------------------------------
// PID controller, positional or incremental, fixed point
// Input stage, then multiply-add-clamp stage (which also updates state) into the
// result register; one transfer per cycle while the result is not stalled.
// Synchronous reset clears errors, accumulators, gains, mode; limits to max.
// ----------------------------------------------------------------------------
module pid_position_delta_controller #(
   parameter int SAMPLE_WIDTH   = pdc_pkg::DEFAULT_SAMPLE_WIDTH,
   parameter int GAIN_FRAC_BITS = pdc_pkg::DEFAULT_GAIN_FRAC_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,

   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_clear,
   input  logic signed [SAMPLE_WIDTH-1:0]        req_set_point,
   input  logic signed [SAMPLE_WIDTH-1:0]        req_feedback,

   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [pdc_pkg::DRIVE_W-1:0]    rsp_drive,
   output logic                                  rsp_saturated,

   input  logic                                  csr_write_enable,
   input  logic [pdc_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [pdc_pkg::CSR_DATA_W-1:0]        csr_write_data
);

   localparam int ERR_W = SAMPLE_WIDTH + 1;
   localparam int D1_W  = SAMPLE_WIDTH + 2;
   localparam int D2_W  = SAMPLE_WIDTH + 3;
   localparam int P_W   = pdc_pkg::GAIN_W + D2_W;
   localparam int ACC_W = pdc_pkg::LIMIT_W + GAIN_FRAC_BITS + 1;
   localparam int SUM_W = ((P_W > ACC_W) ? P_W : ACC_W) + 3;

   // configuration registers
   pdc_pkg::mode_type                   mode_ff;
   logic signed [pdc_pkg::GAIN_W-1:0]   kp_gain_ff;
   logic signed [pdc_pkg::GAIN_W-1:0]   ki_gain_ff;
   logic signed [pdc_pkg::GAIN_W-1:0]   kd_gain_ff;
   logic [pdc_pkg::LIMIT_W-1:0]         out_limit_ff;
   logic [pdc_pkg::LIMIT_W-1:0]         integral_limit_ff;

   // input stage
   logic                     s1_valid_ff;
   logic                     s1_clear_ff;
   logic signed [ERR_W-1:0]  s1_error_ff;
   logic signed [ERR_W-1:0]  s1_error_in;

   // controller state
   logic signed [ERR_W-1:0]  error_last_ff;
   logic signed [ERR_W-1:0]  error_before_last_ff;
   logic signed [ACC_W-1:0]  integral_acc_ff;
   logic signed [ACC_W-1:0]  output_acc_ff;
   logic signed [ACC_W-1:0]  integral_acc_in;
   logic signed [ACC_W-1:0]  output_acc_in;

   // result register
   logic                                rsp_valid_ff;
   logic signed [pdc_pkg::DRIVE_W-1:0]  rsp_drive_ff;
   logic                                rsp_saturated_ff;
   logic                                rsp_saturated_in;

   logic out_free;
   logic s1_advance;

   logic signed [D1_W-1:0]   diff1;
   logic signed [D2_W-1:0]   diff2;
   logic signed [D1_W-1:0]   kp_opnd;
   logic signed [D2_W-1:0]   kd_opnd;
   logic signed [P_W-1:0]    kp_prod;
   logic signed [P_W-1:0]    ki_prod;
   logic signed [P_W-1:0]    kd_prod;
   logic signed [SUM_W-1:0]  olim;
   logic signed [SUM_W-1:0]  ilim;
   logic signed [SUM_W-1:0]  i_sum;
   logic signed [SUM_W-1:0]  i_clamped;
   logic signed [SUM_W-1:0]  v_sum;

   // ------------------------------------------------------------------
   // configuration
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff           <= pdc_pkg::MODE_POSITIONAL;
         kp_gain_ff        <= '0;
         ki_gain_ff        <= '0;
         kd_gain_ff        <= '0;
         out_limit_ff      <= pdc_pkg::LIMIT_RESET;
         integral_limit_ff <= pdc_pkg::LIMIT_RESET;
      end else if (csr_write_enable) begin
         unique case (pdc_pkg::csr_index_type'(csr_index))
            pdc_pkg::CSR_MODE:
               mode_ff <= pdc_pkg::mode_type'(csr_write_data[0]);
            pdc_pkg::CSR_KP_GAIN:        kp_gain_ff <= signed'(csr_write_data);
            pdc_pkg::CSR_KI_GAIN:        ki_gain_ff <= signed'(csr_write_data);
            pdc_pkg::CSR_KD_GAIN:        kd_gain_ff <= signed'(csr_write_data);
            pdc_pkg::CSR_OUT_LIMIT:
               out_limit_ff <= csr_write_data[pdc_pkg::LIMIT_W-1:0];
            pdc_pkg::CSR_INTEGRAL_LIMIT:
               integral_limit_ff <= csr_write_data[pdc_pkg::LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // handshake
   // ------------------------------------------------------------------
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign s1_advance = s1_valid_ff && out_free;
   assign req_stall  = s1_valid_ff && !out_free;

   assign s1_error_in = ERR_W'(req_set_point) - ERR_W'(req_feedback);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s1_clear_ff <= req_clear;
         s1_error_ff <= s1_error_in;
      end
   end

   // ------------------------------------------------------------------
   // datapath
   // ------------------------------------------------------------------
   assign diff1 = D1_W'(s1_error_ff) - D1_W'(error_last_ff);
   assign diff2 = D2_W'(s1_error_ff) - (D2_W'(error_last_ff) <<< 1)
                  + D2_W'(error_before_last_ff);

   // positional uses e and e-e1; incremental uses e-e1 and e-2e1+e2
   assign kp_opnd = (mode_ff == pdc_pkg::MODE_INCREMENTAL) ? diff1 : D1_W'(s1_error_ff);
   assign kd_opnd = (mode_ff == pdc_pkg::MODE_INCREMENTAL) ? diff2 : D2_W'(diff1);

   assign kp_prod = P_W'(kp_gain_ff) * P_W'(kp_opnd);
   assign ki_prod = P_W'(ki_gain_ff) * P_W'(s1_error_ff);
   assign kd_prod = P_W'(kd_gain_ff) * P_W'(kd_opnd);

   assign olim = signed'(SUM_W'({out_limit_ff, {GAIN_FRAC_BITS{1'b0}}}));
   assign ilim = signed'(SUM_W'({integral_limit_ff, {GAIN_FRAC_BITS{1'b0}}}));

   always_comb begin
      i_sum = SUM_W'(integral_acc_ff) + SUM_W'(ki_prod);
      if (i_sum > ilim) begin
         i_clamped = ilim;
      end else if (i_sum < -ilim) begin
         i_clamped = -ilim;
      end else begin
         i_clamped = i_sum;
      end

      if (mode_ff == pdc_pkg::MODE_INCREMENTAL) begin
         v_sum = SUM_W'(output_acc_ff) + SUM_W'(kp_prod) + SUM_W'(ki_prod)
                 + SUM_W'(kd_prod);
         integral_acc_in = integral_acc_ff;
      end else begin
         v_sum = SUM_W'(kp_prod) + i_clamped + SUM_W'(kd_prod);
         integral_acc_in = ACC_W'(i_clamped);
      end

      if (v_sum > olim) begin
         output_acc_in    = ACC_W'(olim);
         rsp_saturated_in = 1'b1;
      end else if (v_sum < -olim) begin
         output_acc_in    = ACC_W'(-olim);
         rsp_saturated_in = 1'b1;
      end else begin
         output_acc_in    = ACC_W'(v_sum);
         rsp_saturated_in = 1'b0;
      end

      // a clear zeroes everything and reports a quiet result
      if (s1_clear_ff) begin
         integral_acc_in  = '0;
         output_acc_in    = '0;
         rsp_saturated_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         error_last_ff        <= '0;
         error_before_last_ff <= '0;
         integral_acc_ff      <= '0;
         output_acc_ff        <= '0;
      end else if (s1_advance) begin
         error_last_ff        <= s1_clear_ff ? '0 : s1_error_ff;
         error_before_last_ff <= s1_clear_ff ? '0 : error_last_ff;
         integral_acc_ff      <= integral_acc_in;
         output_acc_ff        <= output_acc_in;
      end
   end

   // ------------------------------------------------------------------
   // result register
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   // drive is the floor of the accumulator's integer part
   always_ff @(posedge clock) begin
      if (s1_advance) begin
         rsp_drive_ff     <= output_acc_in[ACC_W-1:GAIN_FRAC_BITS];
         rsp_saturated_ff <= rsp_saturated_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_drive     = rsp_drive_ff;
   assign rsp_saturated = rsp_saturated_ff;

`ifndef SYNTHESIS
   a_sat_at_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_saturated_ff |->
         (rsp_drive_ff == signed'(pdc_pkg::DRIVE_W'(out_limit_ff))) ||
         (rsp_drive_ff == -signed'(pdc_pkg::DRIVE_W'(out_limit_ff))))
      else $error("saturated result not at the output limit");

   a_clear_zeroes: assert property (@(posedge clock) disable iff (reset)
      s1_advance && s1_clear_ff |=>
         (error_last_ff == '0) && (output_acc_ff == '0) && (rsp_drive_ff == '0))
      else $error("clear did not zero state and result");

   a_incr_holds_integral: assert property (@(posedge clock) disable iff (reset)
      s1_advance && !s1_clear_ff && (mode_ff == pdc_pkg::MODE_INCREMENTAL) |=>
         $stable(integral_acc_ff))
      else $error("integral changed in incremental mode");
`endif

endmodule

### bench/tb_pid_position_delta_controller.sv
// ----------------------------------------------------------------------------
// Testbench for the positional / incremental PID controller
// Drives setpoint and feedback samples (and clear requests) through the
// request channel under random bursts and response stalls, reprograms mode,
// gains and limits between phases, and checks every response against an
// in-bench fixed-point model, or against the table value for known directed rows.
// ----------------------------------------------------------------------------
module tb_pid_position_delta_controller;

   localparam int SW          = pdc_pkg::DEFAULT_SAMPLE_WIDTH;
   localparam int FRAC        = pdc_pkg::DEFAULT_GAIN_FRAC_BITS;
   localparam int SETTLE      = 4;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RAND_PHASES = 12;
   localparam int PHASE_ITEMS = 112;
   localparam int DIR_ROWS    = 25;

   typedef struct packed {
      logic signed [pdc_pkg::DRIVE_W-1:0] drive;
      logic                               saturated;
   } drive_result_type;

   typedef struct packed {
      pdc_pkg::mode_type           mode;
      logic [pdc_pkg::GAIN_W-1:0]  kp;
      logic [pdc_pkg::GAIN_W-1:0]  ki;
      logic [pdc_pkg::GAIN_W-1:0]  kd;
      logic [pdc_pkg::LIMIT_W-1:0] olim;
      logic [pdc_pkg::LIMIT_W-1:0] ilim;
   } pid_cfg_type;

   typedef struct {
      int                   phase;
      bit                   clear;
      logic signed [SW-1:0] set_point;
      logic signed [SW-1:0] feedback;
      bit                   known;
      int                   drive_known;
      bit                   sat_known;
   } directed_row_type;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_stall;
   logic                               req_clear = 1'b0;
   logic signed [SW-1:0]               req_set_point = '0;
   logic signed [SW-1:0]               req_feedback = '0;
   logic                               rsp_valid;
   logic                               rsp_stall = 1'b0;
   logic signed [pdc_pkg::DRIVE_W-1:0] rsp_drive;
   logic                               rsp_saturated;
   logic                               csr_write_enable = 1'b0;
   logic [pdc_pkg::CSR_INDEX_W-1:0]    csr_index = '0;
   logic [pdc_pkg::CSR_DATA_W-1:0]     csr_write_data = '0;

   // value typed into the directed table, carried alongside the transfer
   bit                        known_check = 1'b0;
   drive_result_type          known_result = '0;

   pid_position_delta_controller dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_clear        (req_clear),
      .req_set_point    (req_set_point),
      .req_feedback     (req_feedback),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_drive        (rsp_drive),
      .rsp_saturated    (rsp_saturated),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // controller model state, starting from the reset values
   pdc_pkg::mode_type            cfg_mode = pdc_pkg::MODE_POSITIONAL;
   longint                       kp_gain = 0;
   longint                       ki_gain = 0;
   longint                       kd_gain = 0;
   logic [pdc_pkg::LIMIT_W-1:0]  lim_out = pdc_pkg::LIMIT_RESET;
   logic [pdc_pkg::LIMIT_W-1:0]  lim_integral = pdc_pkg::LIMIT_RESET;
   longint                       err_last = 0;
   longint                       err_prev = 0;
   longint                       integ_acc = 0;
   longint                       out_acc = 0;

   drive_result_type    pending_drive[$];
   int                  cycle_count = 0;
   int                  mismatches = 0;
   int                  n_items = 0;
   int                  n_clears = 0;
   int                  n_incremental = 0;
   int                  n_saturated = 0;
   int                  n_settings = 0;
   int                  burst_left = 0;
   int                  stall_style = 0;
   int                  stall_run = 0;
   int                  stall_hold = 0;

   function automatic longint clamp_to_limit(longint x, longint lim, output bit hit);
      hit = 1'b1;
      if (x > lim) return lim;
      if (x < -lim) return -lim;
      hit = 1'b0;
      return x;
   endfunction

   function automatic drive_result_type compute_drive(logic clr, logic signed [SW-1:0] sp,
                                                      logic signed [SW-1:0] fb);
      drive_result_type r;
      longint           e, v, olim, ilim;
      bit               hit, ihit;
      if (clr) begin
         err_last  = 0;
         err_prev  = 0;
         integ_acc = 0;
         out_acc   = 0;
         r.drive     = '0;
         r.saturated = 1'b0;
         return r;
      end
      e    = longint'(sp) - longint'(fb);
      olim = longint'(lim_out) <<< FRAC;
      ilim = longint'(lim_integral) <<< FRAC;
      if (cfg_mode == pdc_pkg::MODE_POSITIONAL) begin
         integ_acc = clamp_to_limit(integ_acc + ki_gain * e, ilim, ihit);
         v = kp_gain * e + integ_acc + kd_gain * (e - err_last);
      end else begin
         v = out_acc + kp_gain * (e - err_last) + ki_gain * e
             + kd_gain * (e - 2 * err_last + err_prev);
      end
      out_acc  = clamp_to_limit(v, olim, hit);
      err_prev = err_last;
      err_last = e;
      r.drive     = pdc_pkg::DRIVE_W'(out_acc >>> FRAC);
      r.saturated = hit;
      return r;
   endfunction

   function automatic void load_register(logic [pdc_pkg::CSR_INDEX_W-1:0] idx,
                                         logic [pdc_pkg::CSR_DATA_W-1:0] data);
      case (pdc_pkg::csr_index_type'(idx))
         pdc_pkg::CSR_MODE:           cfg_mode = pdc_pkg::mode_type'(data[0]);
         pdc_pkg::CSR_KP_GAIN:        kp_gain = longint'($signed(data));
         pdc_pkg::CSR_KI_GAIN:        ki_gain = longint'($signed(data));
         pdc_pkg::CSR_KD_GAIN:        kd_gain = longint'($signed(data));
         pdc_pkg::CSR_OUT_LIMIT:      lim_out = data[pdc_pkg::LIMIT_W-1:0];
         pdc_pkg::CSR_INTEGRAL_LIMIT: lim_integral = data[pdc_pkg::LIMIT_W-1:0];
         default: ;
      endcase
   endfunction

   // register writes, transfers and result checks all land on the rising edge
   always @(posedge clock) begin : monitor
      drive_result_type want;
      cycle_count++;
      if (!reset) begin
         if (csr_write_enable) load_register(csr_index, csr_write_data);
         if (req_valid && !req_stall) begin
            if (!req_clear && cfg_mode == pdc_pkg::MODE_INCREMENTAL) n_incremental++;
            want = compute_drive(req_clear, req_set_point, req_feedback);
            if (known_check) want = known_result;
            pending_drive.push_back(want);
            n_items++;
            if (req_clear) n_clears++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (rsp_saturated) n_saturated++;
            if (pending_drive.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("[%0d] unexpected result: drive %0d saturated %0b",
                           cycle_count, rsp_drive, rsp_saturated);
            end else begin
               want = pending_drive.pop_front();
               if (rsp_drive !== want.drive || rsp_saturated !== want.saturated) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("[%0d] mismatch: drive %0d/%0d saturated %0b/%0b (exp/got)",
                              cycle_count, want.drive, rsp_drive,
                              want.saturated, rsp_saturated);
               end
            end
         end
      end
   end

   // receiver: switch between randomly chosen stall styles in runs of random length
   always @(negedge clock) begin
      if (stall_run == 0) begin
         stall_style = $urandom_range(0, 3);
         stall_run   = $urandom_range(20, 120);
      end
      stall_run--;
      case (stall_style)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= (stall_run % 3 == 0);
         default: begin
            if (stall_hold == 0 && $urandom_range(0, 5) == 0)
               stall_hold = $urandom_range(2, 8);
            rsp_stall <= (stall_hold != 0);
            if (stall_hold != 0) stall_hold--;
         end
      endcase
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_drive.size());
      $display("tb_pid_position_delta_controller: FAIL");
      $finish;
   end

   // all driving tasks are entered and left at a falling edge
   task automatic send_sample(bit clr, logic signed [SW-1:0] sp, logic signed [SW-1:0] fb,
                              bit known, drive_result_type known_val);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                   : $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid     <= 1'b1;
      req_clear     <= clr;
      req_set_point <= sp;
      req_feedback  <= fb;
      known_check   <= known;
      known_result  <= known_val;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // drop valid, wait out every pending result and the pipeline tail
   task automatic settle_block();
      req_valid  <= 1'b0;
      burst_left = 0;
      while (pending_drive.size() != 0) @(posedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_reg(pdc_pkg::csr_index_type idx,
                            logic [pdc_pkg::CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(negedge clock);
   endtask

   task automatic apply_config(pid_cfg_type c);
      write_reg(pdc_pkg::CSR_MODE, pdc_pkg::CSR_DATA_W'(c.mode));
      write_reg(pdc_pkg::CSR_KP_GAIN, c.kp);
      write_reg(pdc_pkg::CSR_KI_GAIN, c.ki);
      write_reg(pdc_pkg::CSR_KD_GAIN, c.kd);
      write_reg(pdc_pkg::CSR_OUT_LIMIT, pdc_pkg::CSR_DATA_W'(c.olim));
      write_reg(pdc_pkg::CSR_INTEGRAL_LIMIT, pdc_pkg::CSR_DATA_W'(c.ilim));
      csr_write_enable <= 1'b0;
      @(negedge clock);
      n_settings++;
   endtask

   function automatic logic [pdc_pkg::GAIN_W-1:0] pick_gain();
      int k;
      k = $urandom_range(0, 9);
      if (k == 0) return 16'h7FFF;
      if (k == 1) return 16'h8000;
      if (k == 2) return 16'h0000;
      if (k < 6) return pdc_pkg::GAIN_W'($urandom_range(0, 1024)) - 16'd512;
      if (k < 8) return pdc_pkg::GAIN_W'($urandom_range(0, 8192)) - 16'd4096;
      return pdc_pkg::GAIN_W'($urandom);
   endfunction

   function automatic logic [pdc_pkg::LIMIT_W-1:0] pick_limit();
      int k;
      k = $urandom_range(0, 9);
      if (k == 0) return '0;
      if (k == 1) return pdc_pkg::LIMIT_RESET;
      if (k < 6) return pdc_pkg::LIMIT_W'($urandom_range(1, 400));
      if (k < 8) return pdc_pkg::LIMIT_W'($urandom_range(400, 5000));
      return pdc_pkg::LIMIT_W'($urandom);
   endfunction

   function automatic logic signed [SW-1:0] pick_sample();
      case ($urandom_range(0, 5))
         0: return SW'($urandom);
         1: begin
            case ($urandom_range(0, 3))
               0: return 16'sh7FFF;
               1: return 16'sh8000;
               2: return 16'sh0000;
               default: return 16'shFFFF;
            endcase
         end
         default: return SW'($urandom_range(0, 1000)) - 16'sd500;
      endcase
   endfunction

   pid_cfg_type directed_cfg [6] = '{
      '{pdc_pkg::MODE_POSITIONAL,  16'h0000, 16'h0000, 16'h0000,
        pdc_pkg::LIMIT_RESET, pdc_pkg::LIMIT_RESET},
      '{pdc_pkg::MODE_POSITIONAL,  16'h0100, 16'h0000, 16'h0000,
        pdc_pkg::LIMIT_RESET, pdc_pkg::LIMIT_RESET},
      '{pdc_pkg::MODE_POSITIONAL,  16'h7FFF, 16'h8000, 16'h7FFF,
        15'd0, 15'd0},
      '{pdc_pkg::MODE_POSITIONAL,  16'h0080, 16'h0040, 16'h0100,
        15'd2000, 15'd300},
      '{pdc_pkg::MODE_INCREMENTAL, 16'h8000, 16'h7FFF, 16'h8000,
        pdc_pkg::LIMIT_RESET, pdc_pkg::LIMIT_RESET},
      '{pdc_pkg::MODE_INCREMENTAL, 16'h0180, 16'h0010, 16'hFF00,
        15'd1234, 15'd0}
   };

   // phase 0 runs on reset values; the rest reprogram first, state carries over
   directed_row_type directed_rows [DIR_ROWS] = '{
      '{0, 1'b0,  16'sh7FFF,  16'sh8000, 1'b1,      0, 1'b0},
      '{0, 1'b0,  16'sh8000,  16'sh7FFF, 1'b1,      0, 1'b0},
      '{0, 1'b1, -16'sd1,     16'sd0,    1'b1,      0, 1'b0},
      '{1, 1'b0,  16'sh7FFF,  16'sh8000, 1'b1,  32767, 1'b1},
      '{1, 1'b0,  16'sh8000,  16'sh7FFF, 1'b1, -32767, 1'b1},
      '{1, 1'b0,  16'sd100,   16'sd0,    1'b1,    100, 1'b0},
      '{1, 1'b0, -16'sd1,     16'sd0,    1'b1,     -1, 1'b0},
      '{1, 1'b1,  16'sd5,     16'sd5,    1'b1,      0, 1'b0},
      '{2, 1'b0,  16'sd1000, -16'sd1000, 1'b1,      0, 1'b1},
      '{2, 1'b0,  16'sd0,     16'sd0,    1'b0,      0, 1'b0},
      '{2, 1'b0,  16'sd0,     16'sd0,    1'b1,      0, 1'b0},
      '{3, 1'b0,  16'sd1000,  16'sd0,    1'b0,      0, 1'b0},
      '{3, 1'b0,  16'sd1000,  16'sd200,  1'b0,      0, 1'b0},
      '{3, 1'b0, -16'sd500,   16'sd0,    1'b0,      0, 1'b0},
      '{3, 1'b0,  16'sd7,     16'sd3,    1'b0,      0, 1'b0},
      '{3, 1'b0,  16'sd0,    -16'sd1,    1'b0,      0, 1'b0},
      '{4, 1'b0,  16'sd10,    16'sd0,    1'b0,      0, 1'b0},
      '{4, 1'b0, -16'sd10,    16'sd0,    1'b0,      0, 1'b0},
      '{4, 1'b0,  16'sd3,     16'sd4,    1'b0,      0, 1'b0},
      '{4, 1'b0,  16'sh7FFF,  16'sh8000, 1'b0,      0, 1'b0},
      '{4, 1'b0,  16'sd0,     16'sd0,    1'b0,      0, 1'b0},
      '{5, 1'b0,  16'sd50,    16'sd0,    1'b0,      0, 1'b0},
      '{5, 1'b0,  16'sd50,    16'sd10,   1'b0,      0, 1'b0},
      '{5, 1'b1,  16'sd0,     16'sd0,    1'b1,      0, 1'b0},
      '{5, 1'b0, -16'sd20,    16'sd5,    1'b0,      0, 1'b0}
   };

   initial begin : stimulus
      int                   phase;
      pid_cfg_type          cfg;
      drive_result_type     val;
      logic signed [SW-1:0] sp, fb;
      phase = 0;
      sp = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].phase != phase) begin
            phase = directed_rows[i].phase;
            settle_block();
            apply_config(directed_cfg[phase]);
         end
         val.drive     = pdc_pkg::DRIVE_W'(directed_rows[i].drive_known);
         val.saturated = directed_rows[i].sat_known;
         send_sample(directed_rows[i].clear, directed_rows[i].set_point,
                     directed_rows[i].feedback, directed_rows[i].known, val);
      end

      val = '0;
      for (int p = 0; p < RAND_PHASES; p++) begin
         cfg.mode = pdc_pkg::mode_type'($urandom_range(0, 1));
         cfg.kp   = pick_gain();
         cfg.ki   = pick_gain();
         cfg.kd   = pick_gain();
         cfg.olim = pick_limit();
         cfg.ilim = pick_limit();
         settle_block();
         apply_config(cfg);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(0, 39) == 0) begin
               send_sample(1'b1, SW'($urandom), SW'($urandom), 1'b0, val);
            end else begin
               // hold the setpoint for a while and let feedback track it
               if ($urandom_range(0, 7) == 0) sp = pick_sample();
               if ($urandom_range(0, 3) == 0) fb = pick_sample();
               else fb = sp + SW'($urandom_range(0, 128)) - 16'sd64;
               send_sample(1'b0, sp, fb, 1'b0, val);
            end
         end
      end

      settle_block();
      $display("covered %0d transfers (%0d clears, %0d incremental samples) over %0d settings",
               n_items, n_clears, n_incremental, n_settings + 1);
      $display("%0d results saturated, %0d mismatches, %0d results outstanding",
               n_saturated, mismatches, pending_drive.size());
      if (mismatches == 0 && pending_drive.size() == 0)
         $display("tb_pid_position_delta_controller: PASS");
      else
         $display("tb_pid_position_delta_controller: FAIL");
      $finish;
   end

endmodule
